FILE: src/lobm_pkg.sv
package lobm_pkg;

  localparam int unsigned PRICE_W = 20;
  localparam int unsigned QTY_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned NRES_W  = 6;
  localparam logic [NRES_W-1:0] MAX_RESULTS = NRES_W'(32);

  typedef enum logic [1:0] {
    ACT_LIMIT  = 2'd0,
    ACT_MARKET = 2'd1,
    ACT_MATCH  = 2'd2,
    ACT_CANCEL = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    K_RESTED    = 3'd0,
    K_FILL      = 3'd1,
    K_EXPIRED   = 3'd2,
    K_CROSS     = 3'd3,
    K_CANCELLED = 3'd4,
    K_NOT_FOUND = 3'd5,
    K_FULL      = 3'd6
  } kind_e;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [TIME_W-1:0]  stamp;
    logic [ID_W-1:0]    ident;
  } entry_t;

  typedef struct packed {
    kind_e              kind;
    logic [ID_W-1:0]    taker;
    logic [ID_W-1:0]    maker;
    logic               cside;
    logic [QTY_W-1:0]   tqty;
    logic [PRICE_W-1:0] tprice;
    logic [QTY_W-1:0]   left;
  } result_t;

  // candidate beats current best: price first, then earlier timestamp
  function automatic logic better(logic high_wins, entry_t c, entry_t b);
    logic r;
    if (c.price != b.price) begin
      r = high_wins ? (c.price > b.price) : (c.price < b.price);
    end else begin
      r = c.stamp < b.stamp;
    end
    return r;
  endfunction

endpackage

FILE: src/lobm_ram.sv
module lobm_ram
  import lobm_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/limit_order_book_matcher.sv
// limit order book with price-time priority. each side (bids, asks) is one
// synchronous ram of SIDE_DEPTH entries, kept packed in insertion order with
// an entry count; no clearing pass is needed after reset. a request is
// transferred when start is high and busy is low. results appear one per
// cycle at most on the result ports, each for exactly one cycle with valid_o
// high; the receiver cannot stall them, so sample every valid_o cycle.
// last_o marks the final result of a request (a zero-quantity market order or
// a match with nothing to cross gives no result at all).
// timing: a limit order is answered from the idle state and the next request can follow
// at once. every other request walks the side rams one entry per cycle through
// the single read port: a best-entry scan reads every entry of a side, removing
// entry k reads the entries above it and shifts them down one by one. a market
// fill goes through a check state, one scan, a fill state and a shift; a cross
// trade goes through two scans, the check, second-scan, trade and two removal
// states and up to two shifts; a cancel goes through up to two scans, two check
// states and one shift.
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int unsigned SIDE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic               side_i,
  input  logic [PRICE_W-1:0] price_i,
  input  logic [QTY_W-1:0]   quantity_i,
  input  logic [TIME_W-1:0]  arrival_time_i,
  input  logic [ID_W-1:0]    cancel_id_i,
  output logic               valid_o,
  output logic [2:0]         kind_o,
  output logic [ID_W-1:0]    taker_id_o,
  output logic [ID_W-1:0]    maker_id_o,
  output logic               cancel_side_o,
  output logic [QTY_W-1:0]   trade_qty_o,
  output logic [PRICE_W-1:0] trade_price_o,
  output logic [QTY_W-1:0]   left_qty_o,
  output logic               last_o
);

  localparam int unsigned AW = (SIDE_DEPTH > 1) ? $clog2(SIDE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SIDE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SWEEP, ST_M_CHECK, ST_M_FILL, ST_X_CHECK, ST_X_SCANA,
    ST_X_TRADE, ST_X_RMB, ST_X_RMA, ST_C_CHK0, ST_C_CHK1
  } state_e;

  // what the sweep engine does while it walks a side
  typedef enum logic [1:0] {
    SW_BEST, SW_FIND, SW_SHIFT
  } sw_mode_e;

  state_e            state_q, ret_q;
  sw_mode_e          sw_mode_q;
  logic              sw_side_q;
  logic [CW-1:0]     sw_ptr_q;
  logic              pv_q;
  logic [AW-1:0]     pidx_q;
  logic [CW-1:0]     cnt_q [2];
  logic [ID_W-1:0]   next_id_q;
  entry_t            best_q [2];
  logic [AW-1:0]     bidx_q [2];
  logic              found_q;
  logic [AW-1:0]     fidx_q;
  logic              side_q;
  logic [QTY_W-1:0]  rem_q;
  logic [ID_W-1:0]   id_q;
  logic [ID_W-1:0]   cid_q;
  logic [NRES_W-1:0] n_q;
  logic              rmb_q, rma_q;
  result_t           hold_q;
  logic              hold_v_q;
  result_t           out_q;
  logic              out_v_q, out_last_q;

  logic              re [2];
  logic [AW-1:0]     raddr [2];
  logic              we [2];
  logic [AW-1:0]     waddr [2];
  entry_t            wdata [2];
  entry_t            rdata [2];

  logic              accept, rd_go, opp;
  entry_t            cand, fb, xb, xa, wb;
  logic [QTY_W-1:0]  ftq, fnq, xtq, xnb, xna;
  logic [PRICE_W:0]  xsum;
  logic              cross_ok;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign opp    = ~side_q;
  assign rd_go  = (state_q == ST_SWEEP) && (sw_ptr_q < cnt_q[sw_side_q]);
  assign cand   = rdata[sw_side_q];

  // market fill arithmetic
  assign fb  = best_q[opp];
  assign ftq = (rem_q < fb.qty) ? rem_q : fb.qty;
  assign fnq = fb.qty - ftq;

  // cross arithmetic, floored midpoint
  assign xb       = best_q[0];
  assign xa       = best_q[1];
  assign cross_ok = xb.price >= xa.price;
  assign xtq      = (xb.qty < xa.qty) ? xb.qty : xa.qty;
  assign xnb      = xb.qty - xtq;
  assign xna      = xa.qty - xtq;
  assign xsum     = {1'b0, xb.price} + {1'b0, xa.price};

  always_comb begin
    wb       = '0;
    wb.price = price_i;
    wb.qty   = quantity_i;
    wb.stamp = arrival_time_i;
    wb.ident = next_id_q;
    for (int s = 0; s < 2; s++) begin
      re[s]    = 1'b0;
      raddr[s] = sw_ptr_q[AW-1:0];
      we[s]    = 1'b0;
      waddr[s] = '0;
      wdata[s] = wb;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept && action_e'(action_i) == ACT_LIMIT &&
            cnt_q[side_i] != CW'(SIDE_DEPTH)) begin
          we[side_i]    = 1'b1;
          waddr[side_i] = cnt_q[side_i][AW-1:0];
        end
      end
      ST_SWEEP: begin
        re[sw_side_q] = rd_go;
        // shift down: entry read last cycle lands one place lower
        if (sw_mode_q == SW_SHIFT && pv_q) begin
          we[sw_side_q]    = 1'b1;
          waddr[sw_side_q] = pidx_q - 1'b1;
          wdata[sw_side_q] = cand;
        end
      end
      ST_M_FILL: begin
        if (fnq != '0) begin
          we[opp]        = 1'b1;
          waddr[opp]     = bidx_q[opp];
          wdata[opp]     = fb;
          wdata[opp].qty = fnq;
        end
      end
      ST_X_TRADE: begin
        if (cross_ok) begin
          we[0]        = (xnb != '0);
          waddr[0]     = bidx_q[0];
          wdata[0]     = xb;
          wdata[0].qty = xnb;
          we[1]        = (xna != '0);
          waddr[1]     = bidx_q[1];
          wdata[1]     = xa;
          wdata[1].qty = xna;
        end
      end
      default: ;
    endcase
  end

  for (genvar s = 0; s < 2; s++) begin : g_side
    lobm_ram #(.DEPTH(SIDE_DEPTH), .AW(AW)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[s]),
      .waddr_i (waddr[s]),
      .wdata_i (wdata[s]),
      .re_i    (re[s]),
      .raddr_i (raddr[s]),
      .rdata_o (rdata[s])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      sw_mode_q <= SW_BEST;
      sw_side_q <= 1'b0;
      sw_ptr_q  <= '0;
      pv_q      <= 1'b0;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      next_id_q <= ID_W'(1);
      found_q   <= 1'b0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      n_q       <= '0;
    end else begin
      out_v_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (action_e'(action_i))
              ACT_LIMIT: begin
                out_v_q    <= 1'b1;
                out_last_q <= 1'b1;
                out_q      <= '0;
                if (cnt_q[side_i] == CW'(SIDE_DEPTH)) begin
                  out_q.kind <= K_FULL;
                end else begin
                  out_q.kind     <= K_RESTED;
                  out_q.taker    <= next_id_q;
                  cnt_q[side_i]  <= cnt_q[side_i] + 1'b1;
                  next_id_q      <= next_id_q + 1'b1;
                end
              end
              ACT_MARKET: begin
                id_q      <= next_id_q;
                next_id_q <= next_id_q + 1'b1;
                rem_q     <= quantity_i;
                side_q    <= side_i;
                n_q       <= '0;
                state_q   <= ST_M_CHECK;
              end
              ACT_MATCH: begin
                n_q     <= '0;
                state_q <= ST_X_CHECK;
              end
              ACT_CANCEL: begin
                cid_q     <= cancel_id_i;
                found_q   <= 1'b0;
                sw_mode_q <= SW_FIND;
                sw_side_q <= SIDE_BUY;
                sw_ptr_q  <= '0;
                pv_q      <= 1'b0;
                ret_q     <= ST_C_CHK0;
                state_q   <= ST_SWEEP;
              end
              default: ;
            endcase
          end
        end

        ST_SWEEP: begin
          if (rd_go) begin
            sw_ptr_q <= sw_ptr_q + 1'b1;
            pidx_q   <= sw_ptr_q[AW-1:0];
          end
          pv_q <= rd_go;
          if (pv_q) begin
            unique case (sw_mode_q)
              SW_BEST: begin
                if (pidx_q == '0 || better(sw_side_q == SIDE_BUY, cand,
                                           best_q[sw_side_q])) begin
                  best_q[sw_side_q] <= cand;
                  bidx_q[sw_side_q] <= pidx_q;
                end
              end
              SW_FIND: begin
                if (!found_q && cand.ident == cid_q) begin
                  found_q <= 1'b1;
                  fidx_q  <= pidx_q;
                end
              end
              default: ;
            endcase
          end
          if (!rd_go && !pv_q) begin
            if (sw_mode_q == SW_SHIFT) begin
              cnt_q[sw_side_q] <= cnt_q[sw_side_q] - 1'b1;
            end
            state_q <= ret_q;
          end
        end

        ST_M_CHECK: begin
          if (rem_q != '0 && cnt_q[opp] != '0 && n_q < MAX_RESULTS - 1'b1) begin
            sw_mode_q <= SW_BEST;
            sw_side_q <= opp;
            sw_ptr_q  <= '0;
            pv_q      <= 1'b0;
            ret_q     <= ST_M_FILL;
            state_q   <= ST_SWEEP;
          end else begin
            if (rem_q != '0) begin
              out_v_q     <= 1'b1;
              out_last_q  <= 1'b1;
              out_q       <= '0;
              out_q.kind  <= K_EXPIRED;
              out_q.taker <= id_q;
              out_q.left  <= rem_q;
            end
            state_q <= ST_IDLE;
          end
        end

        ST_M_FILL: begin
          out_v_q      <= 1'b1;
          out_last_q   <= (rem_q == ftq);
          out_q        <= '0;
          out_q.kind   <= K_FILL;
          out_q.taker  <= id_q;
          out_q.maker  <= fb.ident;
          out_q.tqty   <= ftq;
          out_q.tprice <= fb.price;
          rem_q        <= rem_q - ftq;
          n_q          <= n_q + 1'b1;
          if (fnq == '0) begin
            sw_mode_q <= SW_SHIFT;
            sw_side_q <= opp;
            sw_ptr_q  <= CW'(bidx_q[opp]) + 1'b1;
            pv_q      <= 1'b0;
            ret_q     <= ST_M_CHECK;
            state_q   <= ST_SWEEP;
          end else begin
            state_q <= ST_M_CHECK;
          end
        end

        ST_X_CHECK: begin
          if (cnt_q[0] != '0 && cnt_q[1] != '0 && n_q < MAX_RESULTS) begin
            sw_mode_q <= SW_BEST;
            sw_side_q <= SIDE_BUY;
            sw_ptr_q  <= '0;
            pv_q      <= 1'b0;
            ret_q     <= ST_X_SCANA;
            state_q   <= ST_SWEEP;
          end else begin
            // flush the held trade as the final one
            if (hold_v_q) begin
              out_v_q    <= 1'b1;
              out_last_q <= 1'b1;
              out_q      <= hold_q;
            end
            hold_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end

        ST_X_SCANA: begin
          sw_mode_q <= SW_BEST;
          sw_side_q <= SIDE_SELL;
          sw_ptr_q  <= '0;
          pv_q      <= 1'b0;
          ret_q     <= ST_X_TRADE;
          state_q   <= ST_SWEEP;
        end

        ST_X_TRADE: begin
          if (!cross_ok) begin
            if (hold_v_q) begin
              out_v_q    <= 1'b1;
              out_last_q <= 1'b1;
              out_q      <= hold_q;
            end
            hold_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end else begin
            // trades are held one step back so the last one can be flagged
            if (hold_v_q) begin
              out_v_q    <= 1'b1;
              out_last_q <= 1'b0;
              out_q      <= hold_q;
            end
            hold_v_q      <= 1'b1;
            hold_q        <= '0;
            hold_q.kind   <= K_CROSS;
            hold_q.taker  <= xb.ident;
            hold_q.maker  <= xa.ident;
            hold_q.tqty   <= xtq;
            hold_q.tprice <= xsum[PRICE_W:1];
            rmb_q         <= (xnb == '0);
            rma_q         <= (xna == '0);
            n_q           <= n_q + 1'b1;
            state_q       <= ST_X_RMB;
          end
        end

        ST_X_RMB: begin
          if (rmb_q) begin
            sw_mode_q <= SW_SHIFT;
            sw_side_q <= SIDE_BUY;
            sw_ptr_q  <= CW'(bidx_q[0]) + 1'b1;
            pv_q      <= 1'b0;
            ret_q     <= ST_X_RMA;
            state_q   <= ST_SWEEP;
          end else begin
            state_q <= ST_X_RMA;
          end
        end

        ST_X_RMA: begin
          if (rma_q) begin
            sw_mode_q <= SW_SHIFT;
            sw_side_q <= SIDE_SELL;
            sw_ptr_q  <= CW'(bidx_q[1]) + 1'b1;
            pv_q      <= 1'b0;
            ret_q     <= ST_X_CHECK;
            state_q   <= ST_SWEEP;
          end else begin
            state_q <= ST_X_CHECK;
          end
        end

        ST_C_CHK0, ST_C_CHK1: begin
          if (found_q) begin
            out_v_q     <= 1'b1;
            out_last_q  <= 1'b1;
            out_q       <= '0;
            out_q.kind  <= K_CANCELLED;
            out_q.taker <= cid_q;
            out_q.cside <= sw_side_q;
            sw_mode_q   <= SW_SHIFT;
            sw_ptr_q    <= CW'(fidx_q) + 1'b1;
            pv_q        <= 1'b0;
            ret_q       <= ST_IDLE;
            state_q     <= ST_SWEEP;
          end else if (state_q == ST_C_CHK0) begin
            sw_mode_q <= SW_FIND;
            sw_side_q <= SIDE_SELL;
            sw_ptr_q  <= '0;
            pv_q      <= 1'b0;
            ret_q     <= ST_C_CHK1;
            state_q   <= ST_SWEEP;
          end else begin
            out_v_q     <= 1'b1;
            out_last_q  <= 1'b1;
            out_q       <= '0;
            out_q.kind  <= K_NOT_FOUND;
            out_q.taker <= cid_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign valid_o       = out_v_q;
  assign last_o        = out_last_q;
  assign kind_o        = out_q.kind;
  assign taker_id_o    = out_q.taker;
  assign maker_id_o    = out_q.maker;
  assign cancel_side_o = out_q.cside;
  assign trade_qty_o   = out_q.tqty;
  assign trade_price_o = out_q.tprice;
  assign left_qty_o    = out_q.left;

endmodule

FILE: src/lobm_checker.sv
module lobm_checker
  import lobm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [1:0]         action_i,
  input logic               valid_o,
  input logic [2:0]         kind_o,
  input logic [ID_W-1:0]    maker_id_o,
  input logic [QTY_W-1:0]   left_qty_o,
  input logic               last_o
);

  // a limit order answers in the very next cycle with a single result
  a_limit_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i == ACT_LIMIT) |=>
      (valid_o && last_o && (kind_o == K_RESTED || kind_o == K_FULL)))
    else $error("limit order not answered next cycle");

  // single-result kinds always close their request
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (kind_o == K_CANCELLED || kind_o == K_NOT_FOUND ||
                 kind_o == K_FULL || kind_o == K_RESTED)) |-> last_o)
    else $error("single result without last");

  // expiry closes a market order and carries a nonzero remainder
  a_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o == K_EXPIRED) |-> (last_o && left_qty_o != '0))
    else $error("bad expiry report");

  // no result while the block idles except the answer to a limit order
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !$past(busy) && !busy && !$past(start)) |-> 1'b0)
    else $error("result without a request");

  // rested orders carry no counterparty
  a_rested_maker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o == K_RESTED) |-> (maker_id_o == '0))
    else $error("rested order with maker id");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .action_i   (action_i),
  .valid_o    (valid_o),
  .kind_o     (kind_o),
  .maker_id_o (maker_id_o),
  .left_qty_o (left_qty_o),
  .last_o     (last_o)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import lobm_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         action_i = '0;
  logic               side_i = 1'b0;
  logic [PRICE_W-1:0] price_i = '0;
  logic [QTY_W-1:0]   quantity_i = '0;
  logic [TIME_W-1:0]  arrival_time_i = '0;
  logic [ID_W-1:0]    cancel_id_i = '0;
  logic               valid_o;
  logic [2:0]         kind_o;
  logic [ID_W-1:0]    taker_id_o;
  logic [ID_W-1:0]    maker_id_o;
  logic               cancel_side_o;
  logic [QTY_W-1:0]   trade_qty_o;
  logic [PRICE_W-1:0] trade_price_o;
  logic [QTY_W-1:0]   left_qty_o;
  logic               last_o;

  limit_order_book_matcher #(.SIDE_DEPTH(DEPTH)) dut (.*);

  always #1 clk_i = ~clk_i;

  // one expected report from the book
  typedef struct {
    logic [2:0]         kind;
    logic [ID_W-1:0]    taker;
    logic [ID_W-1:0]    maker;
    logic               cside;
    logic [QTY_W-1:0]   tqty;
    logic [PRICE_W-1:0] tprice;
    logic [QTY_W-1:0]   left;
    logic               last;
  } report_t;

  report_t pending_reports[$];
  int errors = 0;
  int cycles = 0;

  // shadow book: index 0 bids, 1 asks, packed in insertion order
  logic [PRICE_W-1:0] bk_price[2][DEPTH];
  logic [QTY_W-1:0]   bk_qty[2][DEPTH];
  logic [TIME_W-1:0]  bk_stamp[2][DEPTH];
  logic [ID_W-1:0]    bk_id[2][DEPTH];
  int                 bk_count[2];
  logic [ID_W-1:0]    id_next;
  logic [ID_W-1:0]    last_id;

  function automatic int best_slot(int s);
    int b = 0;
    for (int i = 1; i < bk_count[s]; i++) begin
      if (bk_price[s][i] != bk_price[s][b]) begin
        if (s == 0 ? bk_price[s][i] > bk_price[s][b] : bk_price[s][i] < bk_price[s][b])
          b = i;
      end else if (bk_stamp[s][i] < bk_stamp[s][b]) begin
        b = i;
      end
    end
    return b;
  endfunction

  function automatic void drop_slot(int s, int k);
    for (int i = k; i + 1 < bk_count[s]; i++) begin
      bk_price[s][i] = bk_price[s][i+1];
      bk_qty[s][i]   = bk_qty[s][i+1];
      bk_stamp[s][i] = bk_stamp[s][i+1];
      bk_id[s][i]    = bk_id[s][i+1];
    end
    bk_count[s]--;
  endfunction

  function automatic void push_report(logic [2:0] k, logic [ID_W-1:0] t, logic [ID_W-1:0] m,
                                      logic cs, logic [QTY_W-1:0] q, logic [PRICE_W-1:0] p,
                                      logic [QTY_W-1:0] l);
    report_t r;
    r = '{k, t, m, cs, q, p, l, 1'b0};
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  // apply one request to the shadow book and queue the reports it causes
  function automatic void book_request(logic [1:0] act, logic sd, logic [PRICE_W-1:0] pr,
                                       logic [QTY_W-1:0] qt, logic [TIME_W-1:0] ts,
                                       logic [ID_W-1:0] cid);
    int n0 = pending_reports.size();
    int nres = 0;
    int k, b, a, o;
    logic [QTY_W-1:0] rem, tq;
    logic [ID_W-1:0] id;
    logic found = 1'b0;
    case (act)
      ACT_LIMIT: begin
        if (bk_count[sd] >= DEPTH) begin
          push_report(K_FULL, '0, '0, 1'b0, '0, '0, '0);
        end else begin
          k = bk_count[sd];
          bk_price[sd][k] = pr;
          bk_qty[sd][k] = qt;
          bk_stamp[sd][k] = ts;
          bk_id[sd][k] = id_next;
          bk_count[sd]++;
          push_report(K_RESTED, id_next, '0, 1'b0, '0, '0, '0);
          last_id = id_next;
          id_next++;
        end
      end
      ACT_MARKET: begin
        id = id_next;
        id_next++;
        o = sd ? 0 : 1;
        rem = qt;
        while (rem > 0 && bk_count[o] > 0 && nres < 31) begin
          k = best_slot(o);
          tq = rem < bk_qty[o][k] ? rem : bk_qty[o][k];
          push_report(K_FILL, id, bk_id[o][k], 1'b0, tq, bk_price[o][k], '0);
          nres++;
          rem -= tq;
          bk_qty[o][k] -= tq;
          if (bk_qty[o][k] == 0) drop_slot(o, k);
        end
        if (rem > 0) push_report(K_EXPIRED, id, '0, 1'b0, '0, '0, rem);
      end
      ACT_MATCH: begin
        while (bk_count[0] > 0 && bk_count[1] > 0 && nres < 32) begin
          b = best_slot(0);
          a = best_slot(1);
          if (bk_price[0][b] < bk_price[1][a]) break;
          tq = bk_qty[0][b] < bk_qty[1][a] ? bk_qty[0][b] : bk_qty[1][a];
          push_report(K_CROSS, bk_id[0][b], bk_id[1][a], 1'b0, tq,
                      PRICE_W'(({1'b0, bk_price[0][b]} + bk_price[1][a]) >> 1), '0);
          nres++;
          bk_qty[0][b] -= tq;
          bk_qty[1][a] -= tq;
          if (bk_qty[0][b] == 0) drop_slot(0, b);
          if (bk_qty[1][a] == 0) drop_slot(1, a);
        end
      end
      default: begin
        // earliest bid with the id wins, asks searched only if no bid has it
        for (int s = 0; s < 2 && !found; s++) begin
          for (int i = 0; i < bk_count[s]; i++) begin
            if (bk_id[s][i] == cid) begin
              drop_slot(s, i);
              push_report(K_CANCELLED, cid, '0, s[0], '0, '0, '0);
              found = 1'b1;
              break;
            end
          end
        end
        if (!found) push_report(K_NOT_FOUND, cid, '0, 1'b0, '0, '0, '0);
      end
    endcase
    if (pending_reports.size() > n0) pending_reports[$].last = 1'b1;
  endfunction

  // one request transfer, after a random hold-off; start stays high between
  // requests sent with no gap
  task automatic send_request(logic [1:0] act, logic sd, logic [PRICE_W-1:0] pr,
                              logic [QTY_W-1:0] qt, logic [TIME_W-1:0] ts,
                              logic [ID_W-1:0] cid, bit pause = 1'b1);
    int gap;
    gap = pause ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18)) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    side_i <= sd;
    price_i <= pr;
    quantity_i <= qt;
    arrival_time_i <= ts;
    cancel_id_i <= cid;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    book_request(act, sd, pr, qt, ts, cid);
  endtask

  task automatic drain_book();
    start <= 1'b0;
    while (pending_reports.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // result checker: every strobe is one transfer
  always @(posedge clk_i) begin
    report_t e;
    if (rst_ni && valid_o) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result kind %0d", kind_o);
        errors++;
      end else begin
        e = pending_reports[0];
        pending_reports.delete(0);
        if (kind_o !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, kind_o); errors++;
        end
        if (taker_id_o !== e.taker) begin
          $error("taker_id exp %0d got %0d", e.taker, taker_id_o); errors++;
        end
        if (maker_id_o !== e.maker) begin
          $error("maker_id exp %0d got %0d", e.maker, maker_id_o); errors++;
        end
        if (cancel_side_o !== e.cside) begin
          $error("cancel_side exp %0d got %0d", e.cside, cancel_side_o); errors++;
        end
        if (trade_qty_o !== e.tqty) begin
          $error("trade_qty exp %0d got %0d", e.tqty, trade_qty_o); errors++;
        end
        if (trade_price_o !== e.tprice) begin
          $error("trade_price exp %0d got %0d", e.tprice, trade_price_o); errors++;
        end
        if (left_qty_o !== e.left) begin
          $error("left_qty exp %0d got %0d", e.left, left_qty_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // field extremes, every action, full side, zero quantities
  task automatic test_directed();
    send_request(ACT_MATCH, 0, 0, 0, 0, 0);                    // empty book, no result
    send_request(ACT_CANCEL, 0, 0, 0, 0, 16'hFFFF);            // not found
    send_request(ACT_MARKET, 0, 0, 16'hFFFF, 0, 0);            // expires whole
    send_request(ACT_MARKET, 1, 0, 0, 0, 0);                   // zero qty, silent
    send_request(ACT_LIMIT, 0, 20'hFFFFF, 16'hFFFF, 32'hFFFFFFFF, 0);
    send_request(ACT_LIMIT, 1, 0, 0, 0, 16'hFFFF);             // zero qty ask
    send_request(ACT_LIMIT, 1, 20'hFFFFF, 100, 5, 0);
    send_request(ACT_MATCH, 0, 0, 0, 0, 0);                    // crosses zero qty first
    send_request(ACT_CANCEL, 0, 0, 0, 0, last_id);
    for (int i = 0; i < DEPTH + 1; i++)                        // fill asks, then full
      send_request(ACT_LIMIT, 1, 20'(1000 + i % 3), 16'(i + 1), 32'(i % 4), 0, 1'b0);
    send_request(ACT_MARKET, 0, 0, 16'hFFFF, 0, 0);            // sweep all asks
    drain_book();
  endtask

  task automatic test_random();
    int n = 0;
    int r;
    logic [ID_W-1:0] cid;
    while (n < 220) begin
      r = $urandom_range(0, 99);
      cid = ($urandom_range(0, 3) != 0 && id_next > 40) ?
            16'(id_next - $urandom_range(1, 40)) : 16'($urandom);
      if (r < 45)
        send_request(ACT_LIMIT, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0 ?
                     20'($urandom) : 20'($urandom_range(990, 1010)),
                     $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200)),
                     $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 3)), 16'($urandom));
      else if (r < 60)
        send_request(ACT_MARKET, 1'($urandom_range(0, 1)), 20'($urandom),
                     $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 300)),
                     32'($urandom), 16'($urandom));
      else if (r < 75)
        send_request(ACT_MATCH, 1'($urandom_range(0, 1)), 20'($urandom), 16'($urandom),
                     32'($urandom), 16'($urandom));
      else
        send_request(ACT_CANCEL, 1'($urandom_range(0, 1)), 20'($urandom), 16'($urandom),
                     32'($urandom), cid);
      n++;
      if (n == 110) drain_book();  // sender waits until every result is in
    end
  endtask

  // limit and cancel pairs sent with no gap, each cancel names the id of the last rested order
  task automatic test_id_wrap();
    for (int i = 0; i < 6; i++) begin
      send_request(ACT_LIMIT, 0, 20'd5, 16'd1, 32'd0, 0, 1'b0);
      send_request(ACT_CANCEL, 0, 0, 0, 0, last_id, 1'b0);
    end
  endtask

  initial begin
    bk_count = '{0, 0};
    id_next = 16'd1;
    last_id = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_id_wrap();
    drain_book();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
